// ===== hw/rtl/heater_pid_fixed_point_defines.svh =====
// Assertion macros shared by the heater PID controller modules.
`ifndef HEATER_PID_FIXED_POINT_DEFINES_SVH
`define HEATER_PID_FIXED_POINT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define HPID_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define HPID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/hpid_pkg.sv =====
// Shared types and constants for the heater PID controller.
package hpid_pkg;

  localparam int PROD_W    = 64;  // gain * value product
  localparam int TERM_W    = 55;  // product / 1000, signed
  localparam int SUM_W     = 58;  // sums of terms
  localparam int LIM_W     = 20;  // q20 output range
  localparam int PADDR_W   = 5;
  localparam int REG_IDX_W = 3;
  localparam int DIGIT_W   = 8;   // divider digit width

  localparam logic [16:0] ALPHA_ONE   = 17'd32768;
  localparam int          ALPHA_SHIFT = 15;

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_RECONF = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_KP    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KI    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KD    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ALPHA = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT = 3'd4;

  typedef struct packed {
    logic signed [31:0] kp;
    logic signed [31:0] ki;
    logic signed [31:0] kd;
    logic        [15:0] alpha;
    logic        [15:0] output_limit;
  } hpid_cfg_t;

  typedef enum logic [1:0] {MUL_FILT, MUL_P, MUL_I, MUL_D} hpid_mul_t;

  typedef enum logic [1:0] {TERM_P, TERM_I, TERM_D} hpid_term_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DELTA,
    ST_FMUL,
    ST_FUPD,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_REBASE,
    ST_FIN1,
    ST_FIN2,
    ST_EMIT
  } hpid_state_t;

  typedef struct packed {
    logic       load;
    logic       clear;
    logic       delta;
    logic       mul_en;
    hpid_mul_t  mul_sel;
    logic       fupd;
    logic       div_start;
    logic       take_term;
    hpid_term_t term_sel;
    logic       rebase;
    logic       fin1;
    logic       fin2;
    logic       emit;
  } hpid_cmd_t;

  typedef struct packed {
    logic started;
    logic div_done;
    logic out_free;
  } hpid_status_t;

endpackage

// ===== hw/rtl/hpid_in_if.sv =====
// Input item channel: opcode, temperature and control error.
interface hpid_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  opcode;
  logic signed [31:0] temperature;
  logic signed [31:0] control_error;

  modport source (output valid, opcode, temperature, control_error, input ready);
  modport sink (input valid, opcode, temperature, control_error, output ready);
endinterface

// ===== hw/rtl/hpid_out_if.sv =====
// Result channel: heater drive.
interface hpid_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] heater_drive;

  modport source (output valid, heater_drive, input ready);
  modport sink (input valid, heater_drive, output ready);
endinterface

// ===== hw/rtl/heater_pid_fixed_point.sv =====
// Heater PID controller, fixed point. An update beat first forms the temperature
// difference and updates the derivative filter, then computes each of the P, I
// and D terms (one product on the shared 33x33 multiplier, then a byte-serial
// divide by 1000), then does conditional integration, clamping and rounding; the
// next beat is taken only after the result has been loaded into the output
// register, which waits while the previous result is still held there. A
// reconfigure beat computes the P term and rebases the integral once an update
// has happened and does nothing before that, a state reset beat clears the state,
// an unused opcode is dropped. Only update beats produce a result.
// Configuration registers sit on the APB port at byte addresses 0, 4, 8, 12
// and 16 and are to be written while the controller is idle.
module heater_pid_fixed_point (
  input  logic                          clk,
  input  logic                          rst,
  hpid_in_if.sink                       item,
  hpid_out_if.source                    result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hpid_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import hpid_pkg::*;

  hpid_cfg_t    cfg;
  hpid_cmd_t    cmd;
  hpid_status_t status;
  logic         in_ready;

  assign item.ready = in_ready;

  hpid_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hpid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_opcode (item.opcode),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  hpid_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg           (cfg),
    .temperature   (item.temperature),
    .control_error (item.control_error),
    .result        (result)
  );

endmodule

// ===== hw/rtl/hpid_regs.sv =====
// APB configuration registers: gains, filter alpha and output limit.
module hpid_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hpid_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output hpid_pkg::hpid_cfg_t        cfg
);
  import hpid_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[PADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp           <= '0;
      cfg.ki           <= '0;
      cfg.kd           <= '0;
      cfg.alpha        <= '0;
      cfg.output_limit <= 16'hFFFF;
    end else if (wr_en) begin
      unique case (idx)
        REG_KP:    cfg.kp           <= pwdata;
        REG_KI:    cfg.ki           <= pwdata;
        REG_KD:    cfg.kd           <= pwdata;
        REG_ALPHA: cfg.alpha        <= pwdata[15:0];
        REG_LIMIT: cfg.output_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_KP:    prdata = cfg.kp;
      REG_KI:    prdata = cfg.ki;
      REG_KD:    prdata = cfg.kd;
      REG_ALPHA: prdata = {16'b0, cfg.alpha};
      REG_LIMIT: prdata = {16'b0, cfg.output_limit};
      default:   prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/hpid_div1000.sv =====
// Signed divide by 1000, truncating toward zero, one byte of dividend per cycle.
module hpid_div1000 (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [hpid_pkg::PROD_W-1:0] dividend,
  output logic                              done,
  output logic signed [hpid_pkg::TERM_W-1:0] quotient
);
  import hpid_pkg::*;

  localparam int          DIGITS   = PROD_W / DIGIT_W;
  localparam int          CNT_W    = $clog2(DIGITS);
  localparam int          QUO_W    = TERM_W - 1;
  localparam int          V_W      = 10 + DIGIT_W;
  localparam int          EST_W    = V_W + 15;
  localparam int          RSHIFT   = 24;
  localparam logic [14:0] RECIP    = 15'd16777;   // floor(2^24 / 1000)
  localparam logic [V_W-1:0] DIVISOR = V_W'(1000);

  logic [PROD_W-1:0]  mag;
  logic [9:0]         rem;
  logic [QUO_W-1:0]   quo;
  logic               neg;
  logic [CNT_W-1:0]   cnt;
  logic               busy;

  logic [V_W-1:0]     v;
  logic [EST_W-1:0]   est;
  logic [DIGIT_W-1:0] q_est;
  logic [V_W-1:0]     q_x1000;
  logic [V_W-1:0]     r_est;
  logic               fix;
  logic [DIGIT_W-1:0] digit;
  logic [V_W-1:0]     r_new;

  // Estimate is exact or one low; a single compare fixes it.
  always_comb begin
    v       = {rem, mag[PROD_W-1 -: DIGIT_W]};
    est     = {{(EST_W-V_W){1'b0}}, v} * {{(EST_W-15){1'b0}}, RECIP};
    q_est   = est[RSHIFT +: DIGIT_W];
    q_x1000 = ({{(V_W-DIGIT_W){1'b0}}, q_est} << 10)
            - ({{(V_W-DIGIT_W){1'b0}}, q_est} << 4)
            - ({{(V_W-DIGIT_W){1'b0}}, q_est} << 3);
    r_est   = v - q_x1000;
    fix     = r_est >= DIVISOR;
    digit   = q_est + {{(DIGIT_W-1){1'b0}}, fix};
    r_new   = fix ? r_est - DIVISOR : r_est;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[PROD_W-1];
      mag <= dividend[PROD_W-1] ? -dividend : dividend;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      mag <= mag << DIGIT_W;
      rem <= r_new[9:0];
      quo <= {quo[QUO_W-DIGIT_W-1:0], digit};
    end
  end

  assign quotient = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

endmodule

// ===== hw/rtl/hpid_datapath.sv =====
// PID datapath: state registers, shared multiplier, divider, filter and output stage.
`include "heater_pid_fixed_point_defines.svh"

module hpid_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  hpid_pkg::hpid_cmd_t     cmd,
  output hpid_pkg::hpid_status_t  status,
  input  hpid_pkg::hpid_cfg_t     cfg,
  input  logic signed [31:0]      temperature,
  input  logic signed [31:0]      control_error,
  hpid_out_if.source              result
);
  import hpid_pkg::*;

  localparam logic [PROD_W-1:0] HALF = PROD_W'(ALPHA_ONE >> 1);

  // model state
  logic                     started;
  logic signed [31:0]       last_temp;
  logic signed [31:0]       fd;
  logic [LIM_W-1:0]         integ;
  logic [LIM_W-1:0]         last_out;

  // working registers
  logic signed [31:0]       temp_in;
  logic signed [31:0]       err_in;
  logic signed [32:0]       diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [TERM_W-1:0] p_term;
  logic signed [TERM_W-1:0] i_term;
  logic signed [TERM_W-1:0] d_term;
  logic [LIM_W-1:0]         icand;
  logic signed [SUM_W-1:0]  pd;
  logic                     out_valid;
  logic [15:0]              drive;

  logic [LIM_W-1:0]         max_q20;
  logic [15:0]              alpha_eff;
  logic signed [31:0]       delta;
  logic signed [32:0]       mul_a;
  logic signed [32:0]       mul_b;
  logic signed [65:0]       mul_full;
  logic                     f_neg;
  logic [PROD_W-1:0]        f_mag;
  logic [PROD_W-1:0]        f_qm;
  logic signed [PROD_W-1:0] f_q;
  logic signed [PROD_W-1:0] f_sum;
  logic signed [31:0]       fd_sat;
  logic                     div_done;
  logic signed [TERM_W-1:0] div_q;
  logic signed [SUM_W-1:0]  cand;
  logic                     commit;
  logic [LIM_W-1:0]         o_val;
  logic [LIM_W-1:0]         reb_val;
  logic                     err_neg;
  logic                     err_pos;

  function automatic logic signed [SUM_W-1:0] zx(input logic [LIM_W-1:0] a);
    return $signed({{(SUM_W-LIM_W){1'b0}}, a});
  endfunction

  function automatic logic signed [SUM_W-1:0] sx(input logic signed [TERM_W-1:0] a);
    return $signed({{(SUM_W-TERM_W){a[TERM_W-1]}}, a});
  endfunction

  function automatic logic [LIM_W-1:0] clamp_q20(input logic signed [SUM_W-1:0] a,
                                                  input logic [LIM_W-1:0] hi);
    logic [LIM_W-1:0] r;
    if (a < 0)
      r = '0;
    else if (a > zx(hi))
      r = hi;
    else
      r = a[LIM_W-1:0];
    return r;
  endfunction

  assign max_q20   = {cfg.output_limit, 4'b0};
  assign alpha_eff = (cfg.alpha == '0 || {1'b0, cfg.alpha} > ALPHA_ONE) ?
                     ALPHA_ONE[15:0] : cfg.alpha;
  assign delta     = started ? temp_in - last_temp : '0;
  assign err_neg   = err_in[31];
  assign err_pos   = !err_in[31] && (err_in != '0);

  // shared multiplier
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_FILT: begin
        mul_a = diff;
        mul_b = $signed({17'b0, alpha_eff});
      end
      MUL_P: begin
        mul_a = {cfg.kp[31], cfg.kp};
        mul_b = {err_in[31], err_in};
      end
      MUL_I: begin
        mul_a = {cfg.ki[31], cfg.ki};
        mul_b = {err_in[31], err_in};
      end
      MUL_D: begin
        mul_a = {cfg.kd[31], cfg.kd};
        mul_b = {fd[31], fd};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // derivative filter: symmetric rounding of step / ALPHA_ONE, then saturate
  always_comb begin
    f_neg = prod[PROD_W-1];
    f_mag = f_neg ? -prod : prod;
    f_qm  = (f_mag + HALF) >> ALPHA_SHIFT;
    f_q   = f_neg ? -$signed(f_qm) : $signed(f_qm);
    f_sum = $signed({{(PROD_W-32){fd[31]}}, fd}) + f_q;
    if (f_sum > $signed(PROD_W'(32'h7FFF_FFFF)))
      fd_sat = 32'sh7FFF_FFFF;
    else if (f_sum < -$signed(PROD_W'(33'h0_8000_0000)))
      fd_sat = 32'sh8000_0000;
    else
      fd_sat = f_sum[31:0];
  end

  // conditional integration and output
  always_comb begin
    cand    = pd + zx(icand);
    commit  = (cand >= 0 && cand <= zx(max_q20)) ||
              (cand > zx(max_q20) && err_neg) ||
              (cand < 0 && err_pos);
    o_val   = clamp_q20(pd + zx(integ), max_q20);
    reb_val = clamp_q20(zx(last_out) - sx(p_term), max_q20);
  end

  hpid_div1000 u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      started   <= 1'b0;
      last_temp <= '0;
      fd        <= '0;
      integ     <= '0;
      last_out  <= '0;
    end else begin
      if (cmd.delta) begin
        started   <= 1'b1;
        last_temp <= temp_in;
      end
      if (cmd.fupd)
        fd <= fd_sat;
      if (cmd.rebase) begin
        integ <= reb_val;
        fd    <= '0;
      end
      if (cmd.fin2 && commit)
        integ <= icand;
      if (cmd.emit)
        last_out <= o_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      temp_in <= temperature;
      err_in  <= control_error;
    end
    if (cmd.delta)
      diff <= {delta[31], delta} - {fd[31], fd};
    if (cmd.mul_en)
      prod <= mul_full[PROD_W-1:0];
    if (cmd.take_term) begin
      unique case (cmd.term_sel)
        TERM_P:  p_term <= div_q;
        TERM_I:  i_term <= div_q;
        TERM_D:  d_term <= div_q;
        default: ;
      endcase
    end
    if (cmd.fin1) begin
      icand <= clamp_q20(zx(integ) + sx(i_term), max_q20);
      pd    <= sx(p_term) - sx(d_term);
    end
    if (cmd.emit)
      drive <= 16'(({1'b0, o_val} + 21'd8) >> 4);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst)
      out_valid <= 1'b0;
    else if (cmd.emit)
      out_valid <= 1'b1;
    else if (result.ready)
      out_valid <= 1'b0;
  end

  assign result.valid        = out_valid;
  assign result.heater_drive = drive;

  assign status.started  = started;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || result.ready;

  `HPID_ASSERT_NEXT(a_drive_matches_q20, cmd.emit,
    drive == 16'(({1'b0, last_out} + 21'd8) >> 4), "drive beat differs from stored output")
  `HPID_ASSERT_NOW(a_started_falls_on_clear, $fell(started),
    $past(cmd.clear) || $past(rst), "started dropped without a clear")
  `HPID_ASSERT_NEXT(a_rebase_in_range, cmd.rebase,
    fd == '0 && integ <= {$past(cfg.output_limit), 4'b0}, "rebase left integral out of range")

endmodule

// ===== hw/rtl/hpid_ctrl.sv =====
// Controller state machine sequencing the PID datapath.
`include "heater_pid_fixed_point_defines.svh"

module hpid_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [1:0]             in_opcode,
  output logic                   in_ready,
  input  hpid_pkg::hpid_status_t status,
  output hpid_pkg::hpid_cmd_t    cmd
);
  import hpid_pkg::*;

  hpid_state_t state;
  hpid_state_t state_next;
  hpid_term_t  term;
  logic        is_reconf;
  logic        accept;

  assign accept = (state == ST_IDLE) && in_valid;

  always_ff @(posedge clk) begin
    if (rst)
      state <= ST_IDLE;
    else
      state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term      <= TERM_P;
      is_reconf <= 1'b0;
    end else begin
      if (accept) begin
        term      <= TERM_P;
        is_reconf <= (in_opcode == OP_RECONF);
      end else if (state == ST_DIV_WAIT && status.div_done) begin
        unique case (term)
          TERM_P:  term <= TERM_I;
          TERM_I:  term <= TERM_D;
          default: term <= TERM_D;
        endcase
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          priority if (in_opcode == OP_UPDATE)
            state_next = ST_DELTA;
          else if (in_opcode == OP_RECONF && status.started)
            state_next = ST_MUL;
          else if (in_opcode == OP_CLEAR)
            state_next = ST_CLEAR;
          else
            state_next = ST_IDLE;
        end
      end
      ST_CLEAR:  state_next = ST_IDLE;
      ST_DELTA:  state_next = ST_FMUL;
      ST_FMUL:   state_next = ST_FUPD;
      ST_FUPD:   state_next = ST_MUL;
      ST_MUL:    state_next = ST_DIV_GO;
      ST_DIV_GO: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          priority if (is_reconf)
            state_next = ST_REBASE;
          else if (term == TERM_D)
            state_next = ST_FIN1;
          else
            state_next = ST_MUL;
        end
      end
      ST_REBASE: state_next = ST_IDLE;
      ST_FIN1:   state_next = ST_FIN2;
      ST_FIN2:   state_next = ST_EMIT;
      ST_EMIT: begin
        if (status.out_free)
          state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.term_sel = term;
    in_ready     = (state == ST_IDLE);
    unique case (state)
      ST_IDLE:   cmd.load = in_valid;
      ST_CLEAR:  cmd.clear = 1'b1;
      ST_DELTA:  cmd.delta = 1'b1;
      ST_FMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_FILT;
      end
      ST_FUPD:   cmd.fupd = 1'b1;
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        unique case (term)
          TERM_P:  cmd.mul_sel = MUL_P;
          TERM_I:  cmd.mul_sel = MUL_I;
          default: cmd.mul_sel = MUL_D;
        endcase
      end
      ST_DIV_GO:   cmd.div_start = 1'b1;
      ST_DIV_WAIT: cmd.take_term = status.div_done;
      ST_REBASE:   cmd.rebase = 1'b1;
      ST_FIN1:     cmd.fin1 = 1'b1;
      ST_FIN2:     cmd.fin2 = 1'b1;
      ST_EMIT:     cmd.emit = status.out_free;
      default: ;
    endcase
  end

  `HPID_ASSERT_NOW(a_emit_needs_room, cmd.emit, status.out_free,
    "result loaded while output register still full")
  `HPID_ASSERT_NOW(a_done_only_waiting, status.div_done, state == ST_DIV_WAIT,
    "divider finished outside its wait state")
  `HPID_ASSERT_NEXT(a_div_not_instant, cmd.div_start, !status.div_done,
    "divider reported done straight after start")

endmodule
